### hw/rtl/assert_macros.svh
// assertion helpers used by amec_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define AMEC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define AMEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/amec_pkg.sv
`default_nettype none
package amec_pkg;

  // echo line geometry
  localparam int DELAY_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);

  // fixed field widths
  localparam int SAMPLE_W = 18;
  localparam int COEF_W   = 16;
  localparam int LEN_W    = 17;
  localparam int OUT_W    = 16;
  localparam int CMP_W    = ADDR_W + LEN_W;

  // rescale divider widths
  localparam int NUM_W = 51;
  localparam int DEN_W = 34;
  localparam int QUO_W = 17;

  // register indexes
  localparam logic [1:0] REG_ECHO_GAIN = 2'd0;
  localparam logic [1:0] REG_DC_POLE   = 2'd1;
  localparam logic [1:0] REG_LP_ALPHA  = 2'd2;
  localparam logic [1:0] REG_DELAY_LEN = 2'd3;

  // register reset values
  localparam logic [COEF_W-1:0] ECHO_GAIN_RST = 16'd22938;
  localparam logic [COEF_W-1:0] DC_POLE_RST   = 16'd65208;
  localparam logic [COEF_W-1:0] LP_ALPHA_RST  = 16'd26214;
  localparam logic [LEN_W-1:0]  DELAY_LEN_RST = 17'd48000;

  typedef struct packed {
    logic [COEF_W-1:0] echo_gain;
    logic [COEF_W-1:0] dc_pole;
    logic [COEF_W-1:0] lp_alpha;
    logic [LEN_W-1:0]  echo_len;
  } cfg_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

endpackage
`default_nettype wire

### hw/rtl/audio_master_effects_chain.sv
// Master effects chain: each input beat carries a stereo frame and an echo-send sample and
// yields one processed stereo beat. Mono = floor((L+R)/2) gets a feedback echo from a
// 65536-entry delay memory, then a DC blocker, one-pole lowpass, clamp to +-1.0 and cubic
// soft clip; each channel is rescaled by shaped/mono and saturated to 16 bits. One frame is
// in flight at a time: a 15-state sequencer around one shared multiplier runs the filter
// steps, then two divisions on one serial divider for the rescale; when L+R is zero the
// divisions are skipped. The input is ready again in the cycle after the result is
// registered, so a new beat is taken only once the last one is through, and later while an
// earlier result still waits on m_tready. After reset the delay memory is cleared one entry
// a cycle, so no beat is taken until the clearing pass is done; configuration writes are
// taken at any time and should be made while idle.
`default_nettype none
module audio_master_effects_chain (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // left_in[17:0], right_in[35:18], echo_send[53:36]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata    // left_out[15:0], right_out[31:16]
);

  amec_pkg::cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_gain <= amec_pkg::ECHO_GAIN_RST;
      cfg.dc_pole   <= amec_pkg::DC_POLE_RST;
      cfg.lp_alpha  <= amec_pkg::LP_ALPHA_RST;
      cfg.echo_len  <= amec_pkg::DELAY_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        amec_pkg::REG_ECHO_GAIN: cfg.echo_gain <= cfg_data[amec_pkg::COEF_W-1:0];
        amec_pkg::REG_DC_POLE:   cfg.dc_pole   <= cfg_data[amec_pkg::COEF_W-1:0];
        amec_pkg::REG_LP_ALPHA:  cfg.lp_alpha  <= cfg_data[amec_pkg::COEF_W-1:0];
        amec_pkg::REG_DELAY_LEN: cfg.echo_len  <= cfg_data;
      endcase
    end
  end

  // processing core
  amec_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

### hw/rtl/amec_echo_ram.sv
`default_nettype none
module amec_echo_ram (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rd_en,
  input  wire logic [amec_pkg::ADDR_W-1:0]   rd_addr,
  output logic      [amec_pkg::SAMPLE_W-1:0] rd_data,
  input  wire logic                          wr_en,
  input  wire logic [amec_pkg::ADDR_W-1:0]   wr_addr,
  input  wire logic [amec_pkg::SAMPLE_W-1:0] wr_data,
  output logic                               ready
);

  logic [amec_pkg::SAMPLE_W-1:0] mem [amec_pkg::DELAY_DEPTH];
  logic                          clearing;
  logic [amec_pkg::ADDR_W-1:0]   clr_addr;

  // clearing pass after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == amec_pkg::ADDR_W'(amec_pkg::DELAY_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = !clearing;

endmodule
`default_nettype wire

### hw/rtl/amec_div.sv
`default_nettype none
module amec_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire amec_pkg::div_req_t   req,
  output logic                      busy,
  output logic                      done,
  output logic signed [amec_pkg::OUT_W-1:0] quo
);

  localparam int NUM_W = amec_pkg::NUM_W;
  localparam int DEN_W = amec_pkg::DEN_W;
  localparam int QUO_W = amec_pkg::QUO_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic             overflow;
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] nsh;
  logic [QUO_W-1:0] q;
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [DEN_W:0]   trial;
  logic             qbit;
  logic [QUO_W-1:0] q_next;

  // saturate a truncated magnitude to 16 bits
  function automatic logic signed [amec_pkg::OUT_W-1:0] sat_quo(
    input logic [QUO_W-1:0] m, input logic n);
    logic signed [amec_pkg::OUT_W-1:0] res;
    if (n) begin
      if (m > QUO_W'(32768)) res = -16'sd32768;
      else                   res = amec_pkg::OUT_W'(~m + 1'b1);
    end else begin
      if (m > QUO_W'(32767)) res = 16'sd32767;
      else                   res = amec_pkg::OUT_W'(m);
    end
    return res;
  endfunction

  // magnitudes and early overflow check
  assign num_mag  = req.num[NUM_W-1] ? NUM_W'(~req.num + 1'b1) : NUM_W'(req.num);
  assign den_mag  = req.den[DEN_W-1] ? DEN_W'(~req.den + 1'b1) : DEN_W'(req.den);
  assign overflow = num_mag >= {den_mag, {QUO_W{1'b0}}};

  // one restoring step
  assign trial  = {rem, nsh[QUO_W-1]};
  assign qbit   = trial >= {1'b0, dreg};
  assign q_next = {q[QUO_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        neg  <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
        rem  <= num_mag[NUM_W-1 -: DEN_W];
        nsh  <= num_mag[QUO_W-1:0];
        dreg <= den_mag;
        q    <= '0;
        cnt  <= CNT_W'(QUO_W);
        if (overflow) begin
          quo  <= (req.num[NUM_W-1] ^ req.den[DEN_W-1]) ? -16'sd32768 : 16'sd32767;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= qbit ? DEN_W'(trial - {1'b0, dreg}) : DEN_W'(trial);
        nsh <= {nsh[QUO_W-2:0], 1'b0};
        q   <= q_next;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo  <= sat_quo(q_next, neg);
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/amec_core.sv
`default_nettype none
`include "assert_macros.svh"
module amec_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire amec_pkg::cfg_t     cfg,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [55:0]        s_tdata,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic      [31:0]        m_tdata
);

  localparam int SW    = amec_pkg::SAMPLE_W;
  localparam int AW    = amec_pkg::ADDR_W;
  localparam int CMP_W = amec_pkg::CMP_W;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_FB   = 15'h0002,
    S_DC   = 15'h0004,
    S_DCD  = 15'h0008,
    S_LP   = 15'h0010,
    S_LPU  = 15'h0020,
    S_SQ   = 15'h0040,
    S_CUBE = 15'h0080,
    S_SH   = 15'h0100,
    S_ML   = 15'h0200,
    S_MR   = 15'h0400,
    S_PR   = 15'h0800,
    S_DL   = 15'h1000,
    S_DR   = 15'h2000,
    S_OUT  = 15'h4000
  } state_t;

  state_t state;

  logic signed [SW-1:0] l, r, send;
  logic signed [SW:0]   sum;
  logic [AW-1:0]        ptr;
  logic signed [SW:0]   x;
  logic signed [23:0]   dpi, dpo, lpv;
  logic signed [16:0]   c, sh;
  logic signed [34:0]   pl, pr;
  logic signed [15:0]   ol, orr;

  logic signed [24:0]   mul_a;
  logic signed [31:0]   mul_b;
  logic signed [56:0]   prod;
  logic signed [56:0]   prod_s16;

  logic                 accept;
  logic                 ram_ready;
  logic [SW-1:0]        ram_q;
  logic                 wr_en;
  logic [SW-1:0]        wr_data;

  logic signed [SW:0]   f;
  logic signed [SW-1:0] mono;
  logic signed [SW:0]   x_next;
  logic signed [26:0]   dc_sum;
  logic signed [24:0]   lp_diff;
  logic signed [26:0]   lp_sum;
  logic signed [16:0]   c_next;
  logic signed [49:0]   cube_t;
  logic signed [49:0]   sh_wide;

  logic [CMP_W-1:0]     len_eff;
  logic [CMP_W-1:0]     ptr_ext;
  logic [CMP_W-1:0]     ptr_inc;

  amec_pkg::div_req_t   div_req;
  logic                 div_busy;
  logic                 div_done;
  logic signed [15:0]   div_quo;

  // saturation and numerator scaling helpers
  function automatic logic signed [SW-1:0] sat_sample(input logic signed [SW+1:0] v);
    logic signed [SW-1:0] res;
    if (v > (SW+2)'(2**(SW-1) - 1))     res = SW'(2**(SW-1) - 1);
    else if (v < -(SW+2)'(2**(SW-1)))   res = SW'(-(2**(SW-1)));
    else                                res = v[SW-1:0];
    return res;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [23:0] res;
    if (v > 27'sd8388607)       res = 24'sd8388607;
    else if (v < -27'sd8388608) res = -24'sd8388608;
    else                        res = v[23:0];
    return res;
  endfunction

  function automatic logic signed [amec_pkg::NUM_W-1:0] scale_num(
    input logic signed [34:0] p);
    return (amec_pkg::NUM_W'(p) <<< 16) - (amec_pkg::NUM_W'(p) <<< 1);
  endfunction

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE) && ram_ready;

  // echo line store
  amec_echo_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (ptr),
    .rd_data (ram_q),
    .wr_en   (wr_en),
    .wr_addr (ptr),
    .wr_data (wr_data),
    .ready   (ram_ready)
  );

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_FB:    begin mul_a = 25'($signed(ram_q)); mul_b = $signed({16'd0, cfg.echo_gain}); end
      S_DC:    begin mul_a = 25'(dpo);            mul_b = $signed({16'd0, cfg.dc_pole});   end
      S_LP:    begin mul_a = lp_diff;             mul_b = $signed({16'd0, cfg.lp_alpha});  end
      S_SQ:    begin mul_a = 25'(c_next);         mul_b = 32'(c_next);                     end
      S_CUBE:  begin mul_a = 25'(c);              mul_b = $signed(prod[31:0]);             end
      S_ML:    begin mul_a = 25'(l);              mul_b = 32'(sh);                         end
      S_MR:    begin mul_a = 25'(r);              mul_b = 32'(sh);                         end
      default: begin mul_a = '0;                  mul_b = '0;                              end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // datapath arithmetic
  assign prod_s16 = prod >>> 16;
  assign f        = $signed(prod_s16[SW:0]);
  assign mono     = $signed(sum[SW:1]);
  assign x_next   = (SW+1)'(mono) + f;
  assign wr_data  = sat_sample((SW+2)'(send) + (SW+2)'(f));
  assign wr_en    = (state == S_DC);
  assign dc_sum   = 27'(x) - 27'(dpi) + 27'($signed(prod_s16[24:0]));
  assign lp_diff  = 25'(dpo) - 25'(lpv);
  assign lp_sum   = 27'(lpv) + 27'($signed(prod_s16[25:0]));
  assign c_next   = (lpv > 24'sd32768) ? 17'sd32768 :
                    (lpv < -24'sd32768) ? -17'sd32768 : lpv[16:0];
  assign cube_t   = (50'(c) <<< 31) + (50'(c) <<< 30) - 50'($signed(prod[47:0]));
  assign sh_wide  = cube_t >>> 31;

  // delay pointer wrap
  always_comb begin
    len_eff = CMP_W'(cfg.echo_len);
    if (len_eff == '0) len_eff = CMP_W'(1);
    if (len_eff > CMP_W'(amec_pkg::DELAY_DEPTH)) len_eff = CMP_W'(amec_pkg::DELAY_DEPTH);
  end
  assign ptr_ext = CMP_W'(ptr);
  assign ptr_inc = ptr_ext + 1'b1;

  // rescale divider requests
  always_comb begin
    div_req.start = ((state == S_PR) && (sum != '0)) || ((state == S_DL) && div_done);
    div_req.num   = (state == S_PR) ? scale_num(pl) : scale_num(pr);
    div_req.den   = amec_pkg::DEN_W'(sum) <<< 15;
  end

  amec_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ptr      <= '0;
      dpi      <= '0;
      dpo      <= '0;
      lpv      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            l     <= $signed(s_tdata[SW-1:0]);
            r     <= $signed(s_tdata[2*SW-1:SW]);
            send  <= $signed(s_tdata[3*SW-1:2*SW]);
            sum   <= (SW+1)'($signed(s_tdata[SW-1:0])) + (SW+1)'($signed(s_tdata[2*SW-1:SW]));
            state <= S_FB;
          end
        end
        S_FB:   state <= S_DC;
        S_DC: begin
          x     <= x_next;
          ptr   <= (ptr_inc >= len_eff) ? '0 : ptr_inc[AW-1:0];
          state <= S_DCD;
        end
        S_DCD: begin
          dpi   <= 24'(x);
          dpo   <= sat24(dc_sum);
          state <= S_LP;
        end
        S_LP:   state <= S_LPU;
        S_LPU: begin
          lpv   <= sat24(lp_sum);
          state <= S_SQ;
        end
        S_SQ: begin
          c     <= c_next;
          state <= S_CUBE;
        end
        S_CUBE: state <= S_SH;
        S_SH: begin
          sh    <= sh_wide[16:0];
          state <= S_ML;
        end
        S_ML:   state <= S_MR;
        S_MR: begin
          pl    <= $signed(prod[34:0]);
          state <= S_PR;
        end
        S_PR: begin
          pr <= $signed(prod[34:0]);
          if (sum == '0) begin
            ol    <= '0;
            orr   <= '0;
            state <= S_OUT;
          end else begin
            state <= S_DL;
          end
        end
        S_DL: begin
          if (div_done) begin
            ol    <= div_quo;
            state <= S_DR;
          end
        end
        S_DR: begin
          if (div_done) begin
            orr   <= div_quo;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {orr, ol};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AMEC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE), "sequencer not idle after reset")
  `AMEC_ASSERT(a_accept_fb, clk, rst, accept |=> (state == S_FB), "accepted beat did not start feedback step")
  `AMEC_ASSERT(a_div_free, clk, rst, div_req.start |-> !div_busy, "divider started while busy")
  `AMEC_ASSERT(a_ptr_wrap, clk, rst, (state == S_DC) |=> (ptr_ext < len_eff), "delay pointer past delay length")

endmodule
`default_nettype wire
